// ----- hdl/canopen_rx_frame_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// CANopen receive decoder assertion macros
// Concurrent assertion helpers shared by the decoder RTL. They compile away
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CANOPEN_RX_FRAME_DECODER_MACROS_SVH
`define CANOPEN_RX_FRAME_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CRFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define CRFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRFD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CRFD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/crfd_pkg.sv -----
// ----------------------------------------------------------------------------
// CANopen receive decoder package
// Shared constants, codes and structures of the receive-frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package crfd_pkg;

  localparam int NodeSlotsDefault = 8;
  localparam int NodeIdW          = 7;
  localparam int NodeListW        = 56;
  localparam int FuncW            = 4;
  localparam int FuncCount        = 6;
  localparam int CfgIndexW        = 3;
  localparam int CfgDataW         = 56;
  localparam int SlotW            = 3;

  localparam logic [31:0] KeyControlword = 32'h0060_4060;
  localparam logic [31:0] KeyStatusword  = 32'h0060_414B;
  // Fault flag: bit 3 of raw payload byte 4.
  localparam int FaultBit = 35;

  localparam logic [FuncCount-1:0][FuncW-1:0] FuncReset =
    {4'd11, 4'd1, 4'd9, 4'd7, 4'd5, 4'd3};

  typedef enum logic [2:0] {
    KIND_TPDO1,
    KIND_TPDO2,
    KIND_TPDO3,
    KIND_TPDO4,
    KIND_EMCY,
    KIND_SDO,
    KIND_UNKNOWN,
    KIND_IGNORED
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_FAULT_RESET,
    ACT_SHUTDOWN,
    ACT_ENABLE
  } action_t;

  typedef enum logic [2:0] {
    REC_OPERATIONAL,
    REC_FAULT_RESET,
    REC_SHUTDOWN,
    REC_ENABLE,
    REC_CHECK
  } recovery_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_NODE_ID_LIST,
    REG_INVERT_MASK,
    REG_TPDO1_FUNCTION,
    REG_TPDO2_FUNCTION,
    REG_TPDO3_FUNCTION,
    REG_TPDO4_FUNCTION,
    REG_EMCY_FUNCTION,
    REG_SDO_REPLY_FUNCTION
  } reg_index_t;

  typedef struct packed {
    logic [NodeListW-1:0]             node_id_list;
    logic [7:0]                       invert_mask;
    logic [FuncCount-1:0][FuncW-1:0]  func;
  } cfg_t;

  // Decoded frame held between the decode and execute stages.
  typedef struct packed {
    logic              found;
    logic [SlotW-1:0]  slot;
    kind_t             kind;
    logic              inv;
    logic              key_cw;
    logic              key_sw;
    logic [63:0]       payload;
  } dec_t;

  typedef struct packed {
    logic              node_found;
    logic [SlotW-1:0]  slot;
    kind_t             frame_kind;
    action_t           action;
    logic [31:0]       position;
    logic [31:0]       velocity;
    logic [15:0]       current;
    logic [15:0]       following_error;
    logic [15:0]       statusword;
    recovery_t         recovery_state;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/crfd_if.sv -----
// ----------------------------------------------------------------------------
// CANopen receive decoder channels
// Valid/ready channels for received frames and for decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfd_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic        remote_request;
  logic [3:0]  byte_count;
  logic [63:0] payload;

  modport source (output valid, frame_id, remote_request, byte_count, payload,
                  input ready);
  modport sink   (input valid, frame_id, remote_request, byte_count, payload,
                  output ready);
endinterface

interface crfd_result_if;
  logic               valid;
  logic               ready;
  logic               node_found;
  logic [2:0]         slot;
  logic [2:0]         frame_kind;
  logic [1:0]         action;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [15:0] current;
  logic signed [15:0] following_error;
  logic [15:0]        statusword;
  logic [2:0]         recovery_state;

  modport source (output valid, node_found, slot, frame_kind, action, position,
                  velocity, current, following_error, statusword,
                  recovery_state, input ready);
  modport sink   (input valid, node_found, slot, frame_kind, action, position,
                  velocity, current, following_error, statusword,
                  recovery_state, output ready);
endinterface

`default_nettype wire

// ----- hdl/crfd_decode.sv -----
// ----------------------------------------------------------------------------
// CANopen receive decoder: decode stage
// Matches the node id against the slot list, classifies the function code,
// checks the SDO keys and registers the decoded beat.
// ----------------------------------------------------------------------------
`default_nettype none

module crfd_decode import crfd_pkg::*; #(
  parameter int NODE_SLOTS = NodeSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        load,
  input  wire logic        advance,
  input  wire logic [10:0] frame_id,
  input  wire logic        remote_request,
  input  wire logic [3:0]  byte_count,
  input  wire logic [63:0] payload,
  output dec_t             dec,
  output logic             dec_valid
);

  logic [NodeIdW-1:0] node;
  logic [FuncW-1:0]   func;
  logic               found;
  logic [SlotW-1:0]   slot;
  kind_t              kind;
  logic [31:0]        word;
  dec_t               dec_next;

  assign node = frame_id[NodeIdW-1:0];
  assign func = frame_id[10:7];

  // Scan from the top so that the lowest matching slot wins.
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int k = NODE_SLOTS - 1; k >= 0; k--) begin
      if (cfg.node_id_list[NodeIdW*k +: NodeIdW] == node) begin
        found = 1'b1;
        slot  = SlotW'(k);
      end
    end
  end

  // Function codes are scanned from the top; the lowest matching index wins.
  always_comb begin
    if (found && !remote_request) begin
      kind = KIND_UNKNOWN;
      for (int f = FuncCount - 1; f >= 0; f--) begin
        if (cfg.func[f] == func) begin
          kind = kind_t'(3'(f));
        end
      end
    end else begin
      kind = KIND_IGNORED;
    end
  end

  // For the key check, bytes at or beyond the length read as zero; only the low word is compared.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      word[8*b +: 8] = (byte_count > 4'(b)) ? payload[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    dec_next.found   = found;
    dec_next.slot    = slot;
    dec_next.kind    = kind;
    dec_next.inv     = cfg.invert_mask[slot];
    dec_next.key_cw  = (word == KeyControlword);
    dec_next.key_sw  = (word == KeyStatusword);
    dec_next.payload = payload;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec <= dec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (load) begin
      dec_valid <= 1'b1;
    end else if (advance) begin
      dec_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crfd_exec.sv -----
// ----------------------------------------------------------------------------
// CANopen receive decoder: execute stage
// Holds the per-slot measurement and recovery tables, applies one decoded
// beat to them and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module crfd_exec import crfd_pkg::*; #(
  parameter int NODE_SLOTS = NodeSlotsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dec_t dec,
  input  wire logic dec_valid,
  input  wire logic advance,
  output res_t      res,
  output logic      res_valid
);

  localparam int TabW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  logic [31:0] position_tab   [NODE_SLOTS];
  logic [31:0] velocity_tab   [NODE_SLOTS];
  logic [15:0] current_tab    [NODE_SLOTS];
  logic [15:0] follow_err_tab [NODE_SLOTS];
  logic [15:0] statusword_tab [NODE_SLOTS];
  recovery_t   recovery_tab   [NODE_SLOTS];

  logic [TabW-1:0] idx;
  logic            wr;
  logic [31:0]     position_next;
  logic [31:0]     velocity_next;
  logic [15:0]     current_next;
  logic [15:0]     follow_err_next;
  logic [15:0]     statusword_next;
  recovery_t       recovery_next;
  action_t         action;
  res_t            res_next;

  assign idx = dec.slot[TabW-1:0];
  assign wr  = advance && dec_valid && dec.found;

  always_comb begin
    position_next   = position_tab[idx];
    velocity_next   = velocity_tab[idx];
    current_next    = current_tab[idx];
    follow_err_next = follow_err_tab[idx];
    statusword_next = statusword_tab[idx];
    recovery_next   = recovery_tab[idx];
    action          = ACT_NONE;
    case (dec.kind)
      KIND_TPDO1: begin
        position_next = dec.inv ? 32'd0 - dec.payload[31:0]  : dec.payload[31:0];
        velocity_next = dec.inv ? 32'd0 - dec.payload[63:32] : dec.payload[63:32];
      end
      KIND_TPDO2: begin
        current_next    = dec.inv ? 16'd0 - dec.payload[15:0] : dec.payload[15:0];
        follow_err_next = dec.payload[31:16];
        statusword_next = dec.payload[47:32];
      end
      KIND_EMCY: begin
        recovery_next = REC_FAULT_RESET;
        action        = ACT_FAULT_RESET;
      end
      KIND_SDO: begin
        if (dec.key_cw) begin
          case (recovery_tab[idx])
            REC_FAULT_RESET: begin
              recovery_next = REC_SHUTDOWN;
              action        = ACT_SHUTDOWN;
            end
            REC_SHUTDOWN: begin
              recovery_next = REC_ENABLE;
              action        = ACT_ENABLE;
            end
            REC_ENABLE: begin
              recovery_next = REC_CHECK;
            end
            default: begin
              recovery_next = recovery_tab[idx];
            end
          endcase
        end else if (dec.key_sw && recovery_tab[idx] == REC_CHECK) begin
          if (dec.payload[FaultBit]) begin
            recovery_next = REC_FAULT_RESET;
            action        = ACT_FAULT_RESET;
          end else begin
            recovery_next = REC_OPERATIONAL;
          end
        end
      end
      default: begin
        action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        position_tab[i]   <= '0;
        velocity_tab[i]   <= '0;
        current_tab[i]    <= '0;
        follow_err_tab[i] <= '0;
        statusword_tab[i] <= '0;
        recovery_tab[i]   <= REC_OPERATIONAL;
      end
    end else if (wr) begin
      position_tab[idx]   <= position_next;
      velocity_tab[idx]   <= velocity_next;
      current_tab[idx]    <= current_next;
      follow_err_tab[idx] <= follow_err_next;
      statusword_tab[idx] <= statusword_next;
      recovery_tab[idx]   <= recovery_next;
    end
  end

  // An unmatched node reports zeros in every value field.
  always_comb begin
    res_next.node_found = dec.found;
    res_next.slot       = dec.slot;
    res_next.frame_kind = dec.kind;
    res_next.action     = action;
    if (dec.found) begin
      res_next.position        = position_next;
      res_next.velocity        = velocity_next;
      res_next.current         = current_next;
      res_next.following_error = follow_err_next;
      res_next.statusword      = statusword_next;
      res_next.recovery_state  = recovery_next;
    end else begin
      res_next.position        = '0;
      res_next.velocity        = '0;
      res_next.current         = '0;
      res_next.following_error = '0;
      res_next.statusword      = '0;
      res_next.recovery_state  = REC_OPERATIONAL;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= dec_valid;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/canopen_rx_frame_decoder.sv -----
// A frame beat accepted into the decode register moves on into the result
// register, which presents its result beat. One frame per cycle while results
// are taken; the decode register and the result register form a two-stage
// pipeline that moves whenever the result register is free.
// Reset (synchronous, active high) clears all slot tables and both valid flags
// and loads the configuration registers with their default function codes.
`default_nettype none
`include "canopen_rx_frame_decoder_macros.svh"

// ----------------------------------------------------------------------------
// CANopen receive-frame decoder
// Decodes received CAN frames per node slot, keeps the latest process data
// of each node and runs a per-node fault-recovery sequence.
// ----------------------------------------------------------------------------

module canopen_rx_frame_decoder import crfd_pkg::*; #(
  parameter int NODE_SLOTS = NodeSlotsDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  crfd_frame_if.sink                frame,
  crfd_result_if.source             result,
  input  wire logic                 wr_en,
  input  wire logic [CfgIndexW-1:0] wr_index,
  input  wire logic [CfgDataW-1:0]  wr_data
);

  cfg_t cfg;
  dec_t dec;
  logic dec_valid;
  res_t res;
  logic res_valid;
  logic advance;
  logic load;

  // Configuration registers. They are to be written only while no beat is in
  // flight (the block does not enforce it), so the decode stage may read them directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id_list <= '0;
      cfg.invert_mask  <= '0;
      cfg.func         <= FuncReset;
    end else if (wr_en) begin
      case (wr_index)
        REG_NODE_ID_LIST:       cfg.node_id_list <= wr_data[NodeListW-1:0];
        REG_INVERT_MASK:        cfg.invert_mask  <= wr_data[7:0];
        REG_TPDO1_FUNCTION:     cfg.func[0]      <= wr_data[FuncW-1:0];
        REG_TPDO2_FUNCTION:     cfg.func[1]      <= wr_data[FuncW-1:0];
        REG_TPDO3_FUNCTION:     cfg.func[2]      <= wr_data[FuncW-1:0];
        REG_TPDO4_FUNCTION:     cfg.func[3]      <= wr_data[FuncW-1:0];
        REG_EMCY_FUNCTION:      cfg.func[4]      <= wr_data[FuncW-1:0];
        REG_SDO_REPLY_FUNCTION: cfg.func[5]      <= wr_data[FuncW-1:0];
        default:                cfg              <= cfg;
      endcase
    end
  end

  // The pipeline advances when the result register is empty or being taken.
  // The decode register accepts a new frame whenever it is empty or its
  // contents move on in the same cycle, so a waiting result blocks the
  // input only once the decode register is full as well.
  assign advance     = !res_valid || result.ready;
  assign frame.ready = !dec_valid || advance;
  assign load        = frame.valid && frame.ready;

  crfd_decode #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_decode (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .load           (load),
    .advance        (advance),
    .frame_id       (frame.frame_id),
    .remote_request (frame.remote_request),
    .byte_count     (frame.byte_count),
    .payload        (frame.payload),
    .dec            (dec),
    .dec_valid      (dec_valid)
  );

  // The execute stage reads and writes the slot tables in the same cycle,
  // so back-to-back frames for one node see each other's updates.
  crfd_exec #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .dec       (dec),
    .dec_valid (dec_valid),
    .advance   (advance),
    .res       (res),
    .res_valid (res_valid)
  );

  assign result.valid           = res_valid;
  assign result.node_found      = res.node_found;
  assign result.slot            = res.slot;
  assign result.frame_kind      = res.frame_kind;
  assign result.action          = res.action;
  assign result.position        = res.position;
  assign result.velocity        = res.velocity;
  assign result.current         = res.current;
  assign result.following_error = res.following_error;
  assign result.statusword      = res.statusword;
  assign result.recovery_state  = res.recovery_state;

  // An unmatched node yields an ignored beat with no action and no recovery.
  `CRFD_ASSERT_IMP(a_unmatched_quiet, clk, rst,
                   result.valid && !result.node_found,
                   result.frame_kind == KIND_IGNORED && result.action == ACT_NONE &&
                   result.recovery_state == REC_OPERATIONAL,
                   "unmatched node produced activity")
  // Only emergency and SDO beats request a controlword action.
  `CRFD_ASSERT_IMP(a_action_kind, clk, rst,
                   result.valid && result.action != ACT_NONE,
                   result.frame_kind == KIND_EMCY || result.frame_kind == KIND_SDO,
                   "action on a non-recovery frame")
  // A fault-reset request always leaves the slot at the first recovery step.
  `CRFD_ASSERT_IMP(a_fault_reset_step, clk, rst,
                   result.valid && result.action == ACT_FAULT_RESET,
                   result.recovery_state == REC_FAULT_RESET,
                   "fault reset with wrong recovery step")
  // With both stages full and the result stalled, no frame may enter.
  `CRFD_ASSERT_IMP(a_full_stall, clk, rst,
                   dec_valid && res_valid && !result.ready,
                   !frame.ready,
                   "frame accepted into a full pipeline")
  // An accepted frame occupies the decode stage in the next cycle.
  `CRFD_ASSERT_NXT(a_load_valid, clk, rst, load, dec_valid,
                   "accepted frame lost in decode stage")

endmodule

`default_nettype wire
